// ===== rtl/tis_pkg.sv =====
// ----------------------------------------------------------------------------
// Text integer field scanner package
// Shared widths, register indexes, codes, payload types and character
// helpers for the scanner's front end, queue, back end and checker.
// ----------------------------------------------------------------------------
package tis_pkg;

	localparam int CHAR_W      = 8;
	localparam int VALUE_W     = 64;
	localparam int HALF_W      = 32;
	localparam int DIGIT_W     = 5;
	localparam int FWIDTH_W    = 8;
	localparam int CFG_DATA_W  = 8;
	localparam int CFG_INDEX_W = 2;
	localparam int QUEUE_DEPTH = 4;

	// Configuration register indexes.
	localparam logic [CFG_INDEX_W-1:0] CFG_RADIX_MODE   = 2'd0;
	localparam logic [CFG_INDEX_W-1:0] CFG_SIGN_ALLOWED = 2'd1;
	localparam logic [CFG_INDEX_W-1:0] CFG_WIDE_RESULT  = 2'd2;
	localparam logic [CFG_INDEX_W-1:0] CFG_FIELD_WIDTH  = 2'd3;

	// Radix codes.
	localparam logic [1:0] RADIX_DEC  = 2'd0;
	localparam logic [1:0] RADIX_OCT  = 2'd1;
	localparam logic [1:0] RADIX_HEX  = 2'd2;
	localparam logic [1:0] RADIX_AUTO = 2'd3;

	// Result status codes.
	localparam logic [1:0] STATUS_MATCH     = 2'd0;
	localparam logic [1:0] STATUS_NO_DIGITS = 2'd1;
	localparam logic [1:0] STATUS_ENDED     = 2'd2;

	// Characters of interest.
	localparam logic [CHAR_W-1:0] CH_SPACE = 8'h20;
	localparam logic [CHAR_W-1:0] CH_TAB   = 8'h09;
	localparam logic [CHAR_W-1:0] CH_CR    = 8'h0D;
	localparam logic [CHAR_W-1:0] CH_PLUS  = 8'h2B;
	localparam logic [CHAR_W-1:0] CH_MINUS = 8'h2D;
	localparam logic [CHAR_W-1:0] CH_0     = 8'h30;
	localparam logic [CHAR_W-1:0] CH_9     = 8'h39;
	localparam logic [CHAR_W-1:0] CH_UA    = 8'h41;
	localparam logic [CHAR_W-1:0] CH_UF    = 8'h46;
	localparam logic [CHAR_W-1:0] CH_UX    = 8'h58;
	localparam logic [CHAR_W-1:0] CH_LA    = 8'h61;
	localparam logic [CHAR_W-1:0] CH_LF    = 8'h66;
	localparam logic [CHAR_W-1:0] CH_LX    = 8'h78;

	localparam logic [DIGIT_W-1:0] DIGIT_NONE = 5'd16;
	localparam logic [DIGIT_W-1:0] BASE_OCT   = 5'd8;
	localparam logic [DIGIT_W-1:0] BASE_DEC   = 5'd10;
	localparam logic [DIGIT_W-1:0] BASE_HEX   = 5'd16;

	typedef struct packed {
		logic [CHAR_W-1:0] character;
		logic              stream_end;
	} scan_in_t;

	typedef struct packed {
		logic [VALUE_W-1:0] value;
		logic [1:0]         status;
		logic               char_consumed;
	} scan_out_t;

	// Character classification handed from the front end to the back end.
	typedef struct packed {
		logic               stream_end;
		logic               blank;
		logic               plus;
		logic               minus;
		logic               zero;
		logic               letter_x;
		logic [DIGIT_W-1:0] digit;
	} char_class_t;

	typedef struct packed {
		logic [1:0]          radix_mode;
		logic                sign_allowed;
		logic                wide_result;
		logic [FWIDTH_W-1:0] field_width;
	} scan_cfg_t;

	typedef enum logic [1:0] {
		PH_IDLE,
		PH_SIGNED,
		PH_ZERO,
		PH_DIGITS
	} scan_phase_t;

	typedef enum logic [2:0] {
		ACT_NONE,
		ACT_FINISH,
		ACT_SIGN,
		ACT_ZERO,
		ACT_PREFIX,
		ACT_DIGIT
	} scan_act_t;

	function automatic logic [DIGIT_W-1:0] digit_value(input logic [CHAR_W-1:0] c);
		logic [DIGIT_W-1:0] d;
		d = DIGIT_NONE;
		if (c >= CH_0 && c <= CH_9) begin
			d = DIGIT_W'(c - CH_0);
		end else if (c >= CH_LA && c <= CH_LF) begin
			d = DIGIT_W'(c - CH_LA) + BASE_DEC;
		end else if (c >= CH_UA && c <= CH_UF) begin
			d = DIGIT_W'(c - CH_UA) + BASE_DEC;
		end
		return d;
	endfunction

	function automatic logic [DIGIT_W-1:0] radix_base(input logic [1:0] r);
		logic [DIGIT_W-1:0] b;
		case (r)
			RADIX_OCT: begin
				b = BASE_OCT;
			end
			RADIX_HEX: begin
				b = BASE_HEX;
			end
			default: begin
				b = BASE_DEC;
			end
		endcase
		return b;
	endfunction

endpackage

// ===== rtl/text_integer_field_scanner.sv =====
// ----------------------------------------------------------------------------
// Text integer field scanner
// Scans integer fields out of a byte stream in the manner of strtol with a
// field width, giving one result per field.
// ----------------------------------------------------------------------------
// Usage
// The character channel (char_valid, char_stall, char_data) takes one byte,
// or an end-of-stream mark, per transfer. The result channel (result_valid,
// result_stall, result_data) gives one item when a field ends: the value,
// a status and char_consumed. char_consumed is always 0 on a result: the
// byte that ended the field belongs to the source again and must be
// presented anew as the next transfer.
// Throughput is one character per cycle unless the queue is empty or a
// field end meets a stalled result. A field's end byte goes through the
// class queue and back end to the result register, behind earlier queued
// bytes. The back end's digit update (shift-add by the radix) sets that rate.
// A stalled result holds in the output register; the back end keeps taking
// characters that do not end a field, and the front end keeps accepting
// until the queue of QUEUE_DEPTH entries fills, then raises char_stall.
// Reset empties the queue and result stage, puts the scanner in whitespace
// skipping and loads the register defaults: decimal, sign allowed, 64-bit
// wraparound, unlimited width. Write the registers only while idle.
// ----------------------------------------------------------------------------
module text_integer_field_scanner
	import tis_pkg::*;
#(
	parameter int QUEUE_DEPTH = tis_pkg::QUEUE_DEPTH
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   cfg_wr_en,
	input  logic [CFG_INDEX_W-1:0] cfg_index,
	input  logic [CFG_DATA_W-1:0]  cfg_data,
	input  logic                   char_valid,
	output logic                   char_stall,
	input  scan_in_t               char_data,
	output logic                   result_valid,
	input  logic                   result_stall,
	output scan_out_t              result_data
);

	scan_cfg_t   cfg_q;
	char_class_t front_class;
	char_class_t head;
	logic        head_valid;
	logic        pop;
	logic        full;
	logic        push;

	// Register file. Each write takes the low bits its register needs.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.radix_mode   <= RADIX_DEC;
			cfg_q.sign_allowed <= 1'b1;
			cfg_q.wide_result  <= 1'b1;
			cfg_q.field_width  <= '0;
		end else if (cfg_wr_en) begin
			case (cfg_index)
				CFG_RADIX_MODE: begin
					cfg_q.radix_mode <= cfg_data[1:0];
				end
				CFG_SIGN_ALLOWED: begin
					cfg_q.sign_allowed <= cfg_data[0];
				end
				CFG_WIDE_RESULT: begin
					cfg_q.wide_result <= cfg_data[0];
				end
				CFG_FIELD_WIDTH: begin
					cfg_q.field_width <= cfg_data[FWIDTH_W-1:0];
				end
				default: begin
					cfg_q <= cfg_q;
				end
			endcase
		end
	end

	// A transfer on the character channel pushes one classified entry.
	assign push       = char_valid && !char_stall;
	assign char_stall = full;

	tis_front u_front (
		.char_data  (char_data),
		.char_class (front_class)
	);

	tis_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_data  (front_class),
		.pop        (pop),
		.head       (head),
		.head_valid (head_valid),
		.full       (full)
	);

	tis_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg          (cfg_q),
		.head         (head),
		.head_valid   (head_valid),
		.pop          (pop),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result_data  (result_data)
	);

endmodule

// ===== rtl/tis_front.sv =====
// ----------------------------------------------------------------------------
// Scanner front end
// Classifies each accepted character: whitespace, sign, zero, letter x and
// digit value, so that the back end works on flags rather than raw bytes.
// ----------------------------------------------------------------------------
module tis_front
	import tis_pkg::*;
(
	input  scan_in_t    char_data,
	output char_class_t char_class
);

	logic [CHAR_W-1:0] c;

	assign c = char_data.character;

	always_comb begin
		char_class.stream_end = char_data.stream_end;
		char_class.blank      = (c == CH_SPACE) || (c >= CH_TAB && c <= CH_CR);
		char_class.plus       = (c == CH_PLUS);
		char_class.minus      = (c == CH_MINUS);
		char_class.zero       = (c == CH_0);
		char_class.letter_x   = (c == CH_LX) || (c == CH_UX);
		char_class.digit      = digit_value(c);
	end

endmodule

// ===== rtl/tis_queue.sv =====
// ----------------------------------------------------------------------------
// Scanner class queue
// Small first-in first-out buffer of classified characters between the
// front end and the back end.
// ----------------------------------------------------------------------------
module tis_queue
	import tis_pkg::*;
#(
	parameter int DEPTH = QUEUE_DEPTH
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        push,
	input  char_class_t push_data,
	input  logic        pop,
	output char_class_t head,
	output logic        head_valid,
	output logic        full
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);
	localparam logic [PTR_W-1:0] LAST = PTR_W'(DEPTH - 1);
	localparam logic [CNT_W-1:0] FULL_COUNT = CNT_W'(DEPTH);

	char_class_t           entry_q [DEPTH];
	logic [PTR_W-1:0]      wr_ptr_q;
	logic [PTR_W-1:0]      rd_ptr_q;
	logic [CNT_W-1:0]      count_q;

	assign head       = entry_q[rd_ptr_q];
	assign head_valid = (count_q != '0);
	assign full       = (count_q == FULL_COUNT);

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == LAST) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == LAST) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

// ===== rtl/tis_back.sv =====
// ----------------------------------------------------------------------------
// Scanner back end
// Runs the field state machine on one classified character per cycle while
// no field end stalls, accumulates digits, drives the registered result stage.
// ----------------------------------------------------------------------------
module tis_back
	import tis_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  scan_cfg_t   cfg,
	input  char_class_t head,
	input  logic        head_valid,
	output logic        pop,
	output logic        result_valid,
	input  logic        result_stall,
	output scan_out_t   result_data
);

	scan_phase_t         phase_q;
	scan_phase_t         phase_d;
	logic [VALUE_W-1:0]  acc_q;
	logic                negative_q;
	logic [1:0]          radix_q;
	logic                seen_q;
	logic [FWIDTH_W-1:0] width_left_q;
	logic                unlimited_q;
	logic                auto_q;
	logic                result_valid_q;
	scan_out_t           result_data_q;

	logic                idle;
	logic                new_field;
	logic                auto_e;
	logic [1:0]          radix_e;
	logic [1:0]          radix_d;
	logic                width_out;
	logic                go;
	scan_phase_t         ph;
	scan_act_t           act;
	logic [1:0]          fin_status;
	logic                out_free;
	logic                fire;

	logic [VALUE_W-1:0]  acc_scaled;
	logic [VALUE_W-1:0]  acc_mac;
	logic [VALUE_W-1:0]  signed_val;
	logic [VALUE_W-1:0]  fin_value;
	logic [FWIDTH_W-1:0] width_src;
	logic                unl_src;
	logic [FWIDTH_W-1:0] width_take;

	// Decide what the head character does to the field.
	always_comb begin
		idle      = (phase_q == PH_IDLE);
		new_field = idle && !head.stream_end && !head.blank;
		auto_e    = new_field ? (cfg.radix_mode == RADIX_AUTO) : auto_q;
		radix_e   = radix_q;
		if (new_field) begin
			radix_e = (cfg.radix_mode == RADIX_AUTO) ? RADIX_DEC : cfg.radix_mode;
		end
		width_out  = !idle && !unlimited_q && (width_left_q == '0);
		ph         = idle ? PH_SIGNED : phase_q;
		radix_d    = radix_e;
		act        = ACT_NONE;
		fin_status = STATUS_MATCH;
		go         = 1'b0;
		if (idle) begin
			if (head.stream_end) begin
				act        = ACT_FINISH;
				fin_status = STATUS_ENDED;
			end else if (!head.blank) begin
				go = 1'b1;
			end
		end else if (width_out) begin
			act        = ACT_FINISH;
			fin_status = seen_q ? STATUS_MATCH : STATUS_NO_DIGITS;
		end else if (head.stream_end) begin
			act        = ACT_FINISH;
			fin_status = seen_q ? STATUS_MATCH : STATUS_ENDED;
		end else begin
			go = 1'b1;
		end
		if (go) begin
			if (new_field && cfg.sign_allowed && (head.plus || head.minus)) begin
				act = ACT_SIGN;
			end else if (ph == PH_SIGNED && head.zero
				&& (auto_e || radix_e == RADIX_HEX)) begin
				act = ACT_ZERO;
			end else if (ph == PH_ZERO && head.letter_x) begin
				act = ACT_PREFIX;
			end else begin
				if (ph == PH_ZERO && auto_e) begin
					radix_d = RADIX_OCT;
				end
				if (head.digit < radix_base(radix_d)) begin
					act = ACT_DIGIT;
				end else begin
					act        = ACT_FINISH;
					fin_status = seen_q ? STATUS_MATCH : STATUS_NO_DIGITS;
				end
			end
		end
	end

	assign out_free     = !result_valid_q || !result_stall;
	assign fire         = head_valid && ((act != ACT_FINISH) || out_free);
	assign pop          = fire;
	assign result_valid = result_valid_q;
	assign result_data  = result_data_q;

	// Next phase.
	always_comb begin
		phase_d = phase_q;
		if (fire) begin
			case (act)
				ACT_FINISH: begin
					phase_d = PH_IDLE;
				end
				ACT_SIGN: begin
					phase_d = PH_SIGNED;
				end
				ACT_ZERO: begin
					phase_d = PH_ZERO;
				end
				ACT_PREFIX, ACT_DIGIT: begin
					phase_d = PH_DIGITS;
				end
				default: begin
					phase_d = phase_q;
				end
			endcase
		end
	end

	// Datapath: multiply by a constant radix as shifts and adds.
	always_comb begin
		case (radix_d)
			RADIX_OCT: begin
				acc_scaled = acc_q << 3;
			end
			RADIX_HEX: begin
				acc_scaled = acc_q << 4;
			end
			default: begin
				acc_scaled = (acc_q << 3) + (acc_q << 1);
			end
		endcase
		acc_mac    = acc_scaled + VALUE_W'(head.digit);
		signed_val = negative_q ? (~acc_q + 1'b1) : acc_q;
		fin_value  = '0;
		if (fin_status == STATUS_MATCH) begin
			fin_value = signed_val;
			if (!cfg.wide_result) begin
				fin_value[VALUE_W-1:HALF_W] = '0;
			end
		end
		width_src  = new_field ? cfg.field_width : width_left_q;
		unl_src    = new_field ? (cfg.field_width == '0) : unlimited_q;
		width_take = (!unl_src && width_src != '0) ? width_src - 1'b1 : width_src;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q      <= PH_IDLE;
			acc_q        <= '0;
			negative_q   <= 1'b0;
			radix_q      <= RADIX_DEC;
			seen_q       <= 1'b0;
			width_left_q <= '0;
			unlimited_q  <= 1'b0;
			auto_q       <= 1'b0;
		end else begin
			phase_q <= phase_d;
			if (fire) begin
				case (act)
					ACT_FINISH: begin
						acc_q        <= '0;
						negative_q   <= 1'b0;
						radix_q      <= RADIX_DEC;
						seen_q       <= 1'b0;
						width_left_q <= '0;
						unlimited_q  <= 1'b0;
						auto_q       <= 1'b0;
					end
					ACT_SIGN, ACT_ZERO, ACT_PREFIX, ACT_DIGIT: begin
						width_left_q <= width_take;
						unlimited_q  <= unl_src;
						auto_q       <= auto_e;
						// A 0x prefix switches the field to hexadecimal.
						radix_q      <= (act == ACT_PREFIX) ? RADIX_HEX : radix_d;
						if (act == ACT_SIGN) begin
							negative_q <= head.minus;
						end
						if (act == ACT_ZERO) begin
							acc_q  <= '0;
							seen_q <= 1'b1;
						end
						if (act == ACT_PREFIX) begin
							seen_q <= 1'b0;
						end
						if (act == ACT_DIGIT) begin
							acc_q  <= acc_mac;
							seen_q <= 1'b1;
						end
					end
					default: begin
						auto_q <= auto_q;
					end
				endcase
			end
		end
	end

	// Result stage: loads on a field end, empties on a transfer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
		end else if (fire && act == ACT_FINISH) begin
			result_valid_q <= 1'b1;
		end else if (!result_stall) begin
			result_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (fire && act == ACT_FINISH) begin
			result_data_q.value         <= fin_value;
			result_data_q.status        <= fin_status;
			result_data_q.char_consumed <= 1'b0;
		end
	end

endmodule

// ===== rtl/tis_checker.sv =====
// ----------------------------------------------------------------------------
// Scanner port checker
// Watches the top level's ports for result stage slips and is bound to
// the top level.
// ----------------------------------------------------------------------------
module tis_checker
	import tis_pkg::*;
(
	input logic                   clk,
	input logic                   arst_n,
	input logic                   cfg_wr_en,
	input logic [CFG_INDEX_W-1:0] cfg_index,
	input logic [CFG_DATA_W-1:0]  cfg_data,
	input logic                   result_valid,
	input logic                   result_stall,
	input scan_out_t              result_data
);

	logic wide_q;

	// Mirror of the wraparound register as written through the port.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wide_q <= 1'b1;
		end else if (cfg_wr_en && cfg_index == CFG_WIDE_RESULT) begin
			wide_q <= cfg_data[0];
		end
	end

	a_result_holds: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result_stall |=> result_valid && $stable(result_data))
		else $error("result changed while stalled");

	a_never_consumed: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> !result_data.char_consumed)
		else $error("result marks its character as consumed");

	a_miss_is_zero: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && (result_data.status == STATUS_NO_DIGITS
		|| result_data.status == STATUS_ENDED) |-> result_data.value == '0)
		else $error("failed match carries a nonzero value");

	a_narrow_wrap: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !wide_q |-> result_data.value[VALUE_W-1:HALF_W] == '0)
		else $error("32-bit result has upper bits set");

endmodule

bind text_integer_field_scanner tis_checker u_tis_checker (.*);
